// ===== design/pmss_pkg.sv =====
`timescale 1ns / 1ps
package pmss_pkg;

    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_PICK   = 1'b1;

    localparam logic [15:0] DEFAULT_PERIOD_RST = 16'd10;

    // elapsed sends fit 33 bits, times a 16 bit period
    localparam int NUM_W  = 33;
    localparam int PROD_W = NUM_W + 16;

    typedef enum logic [2:0] {
        STAT_UPDATED = 3'd0,
        STAT_ADDED   = 3'd1,
        STAT_FULL    = 3'd2,
        STAT_BANNED  = 3'd3,
        STAT_PICKED  = 3'd4,
        STAT_NONE    = 3'd5
    } stat_t;

    typedef struct packed {
        logic        req_type;
        logic [23:0] msg_id;
        logic [7:0]  sys_id;
        logic [7:0]  comp_id;
        logic [15:0] stream_period;
        logic        is_banned;
        logic [15:0] payload_handle;
    } req_t;

    typedef struct packed {
        stat_t       status;
        logic [4:0]  slot;
        logic [23:0] out_msg_id;
        logic [7:0]  out_sys_id;
        logic [7:0]  out_comp_id;
        logic [15:0] out_handle;
        logic [31:0] send_index;
    } rsp_t;

    typedef struct packed {
        logic [23:0]        key_msg;
        logic [7:0]         key_sys;
        logic [7:0]         key_comp;
        logic [15:0]        period;
        logic signed [32:0] last_send;
        logic               fresh;
        logic [15:0]        handle;
    } entry_t;

    typedef struct packed {
        logic start;
        logic scan_step;
        logic fetch;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic scan_last;
        logic pipe_busy;
    } sts_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FETCH,
        S_COMMIT
    } state_t;

endpackage

// ===== design/pmss_dp.sv =====
`timescale 1ns / 1ps
module pmss_dp
    import pmss_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  req_t        s_data,
    input  logic [15:0] default_period,
    output rsp_t        rsp
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

    entry_t mem [TABLE_DEPTH];

    req_t             req_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [31:0]      sends_reg;
    logic [31:0]      sends_next;
    entry_t           rd_data_reg;
    logic [IDX_W-1:0] scan_idx_reg;
    logic             v1_reg;
    logic [IDX_W-1:0] idx1_reg;
    logic             v2_reg;
    logic [IDX_W-1:0] idx2_reg;
    logic [NUM_W-1:0] num2_reg;
    logic [15:0]      per2_reg;
    logic             cand2_reg;
    logic             match2_reg;
    logic             found_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [NUM_W-1:0] best_num_reg;
    logic [15:0]      best_per_reg;
    logic             hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;

    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;
    logic [33:0]       diff;
    logic              pos;
    logic              key_eq;
    logic [PROD_W-1:0] p_new;
    logic [PROD_W-1:0] p_best;
    logic              better;
    logic [15:0]       per_eff;

    assign rd_addr = cmd.fetch ? ((req_reg.req_type == REQ_PICK) ? best_idx_reg : hit_idx_reg)
                               : scan_idx_reg;

    always_ff @(posedge aclk) begin
        if (cmd.commit && wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.scan_step || cmd.fetch) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // stage 2: elapsed sends and key match of the entry just read
    assign diff   = {2'b00, sends_reg} - {rd_data_reg.last_send[32], rd_data_reg.last_send};
    assign pos    = !diff[33] && (diff != '0);
    assign key_eq = (rd_data_reg.key_msg == req_reg.msg_id)
                 && (rd_data_reg.key_sys == req_reg.sys_id)
                 && (rd_data_reg.key_comp == req_reg.comp_id);

    // stage 3: num/per > best_num/best_per by cross multiplication
    assign p_new  = PROD_W'(num2_reg) * PROD_W'(best_per_reg);
    assign p_best = PROD_W'(best_num_reg) * PROD_W'(per2_reg);
    assign better = !found_reg || (p_new > p_best);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            found_reg <= 1'b0;
            hit_reg   <= 1'b0;
            count_reg <= '0;
            sends_reg <= '0;
        end else begin
            v1_reg <= cmd.scan_step;
            v2_reg <= v1_reg;
            if (cmd.start) begin
                found_reg <= 1'b0;
                hit_reg   <= 1'b0;
            end else if (v2_reg) begin
                if (cand2_reg && better) begin
                    found_reg <= 1'b1;
                end
                if (match2_reg) begin
                    hit_reg <= 1'b1;
                end
            end
            if (cmd.commit) begin
                count_reg <= count_next;
                sends_reg <= sends_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            req_reg      <= s_data;
            scan_idx_reg <= '0;
            best_num_reg <= '0;
            best_per_reg <= 16'd1;
        end else begin
            if (cmd.scan_step) begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            end
            if (v2_reg) begin
                if (cand2_reg && better) begin
                    best_idx_reg <= idx2_reg;
                    best_num_reg <= num2_reg;
                    best_per_reg <= per2_reg;
                end
                // first match in index order wins
                if (match2_reg && !hit_reg) begin
                    hit_idx_reg <= idx2_reg;
                end
            end
        end
        idx1_reg   <= scan_idx_reg;
        idx2_reg   <= idx1_reg;
        num2_reg   <= diff[NUM_W-1:0];
        per2_reg   <= rd_data_reg.period;
        cand2_reg  <= rd_data_reg.fresh && pos;
        match2_reg <= key_eq;
        if (cmd.commit) begin
            rsp_reg <= rsp_next;
        end
    end

    always_comb begin
        per_eff = req_reg.stream_period;
        if (per_eff == 16'd0) begin
            per_eff = default_period;
        end
        if (per_eff == 16'd0) begin
            per_eff = 16'd1;
        end
    end

    always_comb begin
        rsp_next   = '0;
        wr_en      = 1'b0;
        wr_addr    = hit_idx_reg;
        wr_data    = rd_data_reg;
        count_next = count_reg;
        sends_next = sends_reg;
        if (req_reg.req_type == REQ_UPDATE) begin
            if (hit_reg) begin
                wr_en           = 1'b1;
                wr_data.handle  = req_reg.payload_handle;
                wr_data.fresh   = 1'b1;
                rsp_next.status = STAT_UPDATED;
                rsp_next.slot   = 5'(hit_idx_reg);
            end else if (req_reg.is_banned) begin
                rsp_next.status = STAT_BANNED;
            end else if (count_reg >= FULL_CNT) begin
                rsp_next.status = STAT_FULL;
            end else begin
                wr_en             = 1'b1;
                wr_addr           = count_reg[IDX_W-1:0];
                wr_data.key_msg   = req_reg.msg_id;
                wr_data.key_sys   = req_reg.sys_id;
                wr_data.key_comp  = req_reg.comp_id;
                wr_data.period    = per_eff;
                wr_data.last_send = -$signed({17'd0, per_eff});
                wr_data.handle    = req_reg.payload_handle;
                wr_data.fresh     = 1'b1;
                count_next        = count_reg + CNT_W'(1);
                rsp_next.status   = STAT_ADDED;
                rsp_next.slot     = 5'(count_reg);
            end
        end else begin
            if (found_reg) begin
                wr_en                = 1'b1;
                wr_addr              = best_idx_reg;
                wr_data.fresh        = 1'b0;
                wr_data.last_send    = $signed({1'b0, sends_reg});
                rsp_next.status      = STAT_PICKED;
                rsp_next.slot        = 5'(best_idx_reg);
                rsp_next.out_msg_id  = rd_data_reg.key_msg;
                rsp_next.out_sys_id  = rd_data_reg.key_sys;
                rsp_next.out_comp_id = rd_data_reg.key_comp;
                rsp_next.out_handle  = rd_data_reg.handle;
                rsp_next.send_index  = sends_reg;
                if (sends_reg != '1) begin
                    sends_next = sends_reg + 32'd1;
                end
            end else begin
                rsp_next.status = STAT_NONE;
            end
        end
    end

    assign sts.count_zero = (count_reg == '0);
    assign sts.scan_last  = ((CNT_W'(scan_idx_reg) + CNT_W'(1)) == count_reg);
    assign sts.pipe_busy  = v1_reg || v2_reg;
    assign rsp            = rsp_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("entry count beyond table depth");

    a_sends_monotone: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> sends_reg >= $past(sends_reg))
        else $error("send counter went backwards");

    a_best_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg && !v2_reg |-> CNT_W'(best_idx_reg) < count_reg)
        else $error("picked entry outside filled table");

endmodule

// ===== design/pmss_ctrl.sv =====
`timescale 1ns / 1ps
module pmss_ctrl
    import pmss_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = sts.count_zero ? S_FETCH : S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!sts.pipe_busy) begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                // hold here while the previous result is still waiting
                if (!m_valid_reg || m_ready) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

    a_commit_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_COMMIT |-> !sts.pipe_busy)
        else $error("commit while scan pipeline still busy");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("new transaction taken while one is in progress");

endmodule

// ===== design/periodic_message_send_scheduler.sv =====
`timescale 1ns / 1ps
// periodic message send scheduler
//
// s_valid/s_ready/s_data carries one request transaction: an update with a
// received message (req_type 0) or a pick of the next message to send
// (req_type 1). every request yields exactly one result transaction on
// m_valid/m_ready/m_data. cfg_wr_en/cfg_wr_data write the default period;
// the user must do so only while the block is idle, which is not enforced.
//
// each request scans the stream table once, one entry a cycle through the
// single read port of the table memory, then reads the chosen entry again
// and writes it back; on an empty table the scan is skipped. one request is
// in progress at a time; the next one is taken as soon as the previous
// result is registered.
//
// reset clears the entry count and the send counter and sets the default
// period to 10; table contents need no clearing. when the receiver stalls,
// the result holds on m_data and the block accepts one more request, which
// completes its scan and then waits until the pending result is taken.
module periodic_message_send_scheduler
    import pmss_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  req_t        s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output rsp_t        m_data,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    logic [15:0] default_period_reg;
    cmd_t        cmd;
    sts_t        sts;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_period_reg <= DEFAULT_PERIOD_RST;
        end else if (cfg_wr_en) begin
            default_period_reg <= cfg_wr_data;
        end
    end

    pmss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pmss_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_data         (s_data),
        .default_period (default_period_reg),
        .rsp            (m_data)
    );

endmodule
